// ===== sv/dtpc_pkg.sv =====
package dtpc_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PUMP_THRESHOLD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TANK_POLL_ENABLE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PANEL_POLL_ENABLE = 2'd2;

   // configuration reset values
   localparam logic [7:0] THRESHOLD_RESET   = 8'd40;
   localparam logic       TANK_POLL_RESET   = 1'b1;
   localparam logic       PANEL_POLL_RESET  = 1'b0;

   // sensor commands
   localparam logic [7:0] CMD_CONVERT = 8'hEE;
   localparam logic [7:0] CMD_STATUS  = 8'hAC;
   localparam logic [7:0] CMD_READ    = 8'hAA;

   // sequence and conversion constants
   localparam logic [4:0] STEPS_PER_SENSOR = 5'd9;
   localparam logic [4:0] LAST_STEP        = 5'd17;
   localparam int         DONE_BIT         = 7;
   localparam logic [7:0] SIGN_NEG         = 8'd255;
   localparam logic [7:0] NEG_BASE         = 8'd128;

   // position inside one sensor's sequence
   typedef enum logic [3:0] {
      SUB_CONVERT_CMD,
      SUB_GAP_CONVERT,
      SUB_STATUS_CMD,
      SUB_STATUS_READ,
      SUB_GAP_STATUS,
      SUB_READ_CMD,
      SUB_TEMP_READ,
      SUB_SIGN_READ,
      SUB_GAP_END
   } sub_type;

   typedef struct packed {
      logic [7:0] pump_threshold;
      logic       tank_poll_enable;
      logic       panel_poll_enable;
   } cfg_type;

   typedef struct packed {
      logic       tank_clock;
      logic       tank_reset_line;
      logic       tank_data_out;
      logic       panel_clock;
      logic       panel_reset_line;
      logic       panel_data_out;
      logic       data_drive;
      logic       pump_off;
      logic [7:0] tank_magnitude;
      logic       tank_negative;
      logic [7:0] panel_magnitude;
      logic       panel_negative;
   } result_type;

endpackage

// ===== sv/dtpc_ifs.sv =====
interface dtpc_req_if;
   logic valid;
   logic ready;
   logic tank_data_in;
   logic panel_data_in;

   modport source (output valid, output tank_data_in, output panel_data_in, input ready);
   modport sink   (input valid, input tank_data_in, input panel_data_in, output ready);
endinterface

interface dtpc_rsp_if;
   logic       valid;
   logic       ready;
   logic       tank_clock;
   logic       tank_reset_line;
   logic       tank_data_out;
   logic       panel_clock;
   logic       panel_reset_line;
   logic       panel_data_out;
   logic       data_drive;
   logic       pump_off;
   logic [7:0] tank_magnitude;
   logic       tank_negative;
   logic [7:0] panel_magnitude;
   logic       panel_negative;

   modport source (
      output valid, output tank_clock, output tank_reset_line, output tank_data_out,
      output panel_clock, output panel_reset_line, output panel_data_out,
      output data_drive, output pump_off, output tank_magnitude, output tank_negative,
      output panel_magnitude, output panel_negative, input ready
   );
   modport sink (
      input valid, input tank_clock, input tank_reset_line, input tank_data_out,
      input panel_clock, input panel_reset_line, input panel_data_out,
      input data_drive, input pump_off, input tank_magnitude, input tank_negative,
      input panel_magnitude, input panel_negative, output ready
   );
endinterface

// ===== sv/dtpc_seq.sv =====
module dtpc_seq
   import dtpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       tank_din,
   input  logic       panel_din,
   input  cfg_type    cfg,
   output result_type result
);

   logic [4:0] step_ff, step_in;
   logic [2:0] bit_ff, bit_in;
   logic       phase_ff, phase_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] raw_ff, raw_in;
   logic [7:0] tank_val_ff, tank_val_in;
   logic       tank_neg_ff, tank_neg_in;
   logic [7:0] panel_val_ff, panel_val_in;
   logic       panel_neg_ff, panel_neg_in;
   logic       pump_off_ff, pump_off_in;

   logic       active;
   logic       sensor;
   logic [4:0] sub_raw;
   sub_type    sub;
   logic       din;
   logic       is_byte;
   logic       is_send;
   logic [7:0] cmd;
   logic       clk;
   logic       rst;
   logic       dout;
   logic       drive;
   logic       poll;
   logic       sign_neg;
   logic [7:0] half;
   logic [7:0] mag;
   logic       pump_on;

   // decode the sequence step
   assign active  = (step_ff <= LAST_STEP);
   assign sensor  = (step_ff >= STEPS_PER_SENSOR);
   assign sub_raw = sensor ? (step_ff - STEPS_PER_SENSOR) : step_ff;
   assign sub     = sub_type'(sub_raw[3:0]);
   assign din     = sensor ? panel_din : tank_din;
   assign poll    = sensor ? cfg.panel_poll_enable : cfg.tank_poll_enable;

   // byte step kind and command
   always_comb begin
      is_byte = 1'b1;
      is_send = 1'b0;
      cmd     = '0;
      case (sub)
         SUB_CONVERT_CMD: begin
            is_send = 1'b1;
            cmd     = CMD_CONVERT;
         end
         SUB_STATUS_CMD: begin
            is_send = 1'b1;
            cmd     = CMD_STATUS;
         end
         SUB_READ_CMD: begin
            is_send = 1'b1;
            cmd     = CMD_READ;
         end
         SUB_STATUS_READ, SUB_TEMP_READ, SUB_SIGN_READ: begin
            is_byte = 1'b1;
         end
         default: begin
            is_byte = 1'b0;
         end
      endcase
   end

   // temperature conversion from raw byte and sign byte
   assign half     = {1'b0, raw_ff[7:1]};
   assign sign_neg = (shift_ff == SIGN_NEG);
   assign mag      = sign_neg ? (NEG_BASE - half) : half;

   // pump decision from the stored readings
   assign pump_on = !tank_neg_ff && !panel_neg_ff &&
                    (panel_val_ff > cfg.pump_threshold) && (panel_val_ff >= tank_val_ff);

   // next state for one tick
   always_comb begin
      step_in      = step_ff;
      bit_in       = bit_ff;
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      raw_in       = raw_ff;
      tank_val_in  = tank_val_ff;
      tank_neg_in  = tank_neg_ff;
      panel_val_in = panel_val_ff;
      panel_neg_in = panel_neg_ff;
      pump_off_in  = pump_off_ff;
      clk          = 1'b1;
      rst          = 1'b0;
      dout         = 1'b0;
      drive        = 1'b0;
      if (!active) begin
         step_in  = '0;
         bit_in   = '0;
         phase_in = 1'b0;
      end else if (is_byte) begin
         clk      = phase_ff;
         rst      = 1'b1;
         phase_in = !phase_ff;
         if (is_send) begin
            drive = 1'b1;
            dout  = cmd[bit_ff];
         end else if (!phase_ff) begin
            shift_in[bit_ff] = din;
         end
         if (phase_ff) begin
            if (bit_ff == 3'd7) begin
               bit_in  = '0;
               step_in = step_ff + 5'd1;
               if (sub == SUB_TEMP_READ) begin
                  raw_in = shift_ff;
               end
               if (sub == SUB_SIGN_READ) begin
                  if (sensor) begin
                     panel_val_in = mag;
                     panel_neg_in = sign_neg;
                  end else begin
                     tank_val_in = mag;
                     tank_neg_in = sign_neg;
                  end
               end
            end else begin
               bit_in = bit_ff + 3'd1;
            end
         end
      end else begin
         bit_in   = '0;
         phase_in = 1'b0;
         if (sub == SUB_GAP_CONVERT) begin
            step_in = poll ? (step_ff + 5'd1) : (step_ff + 5'd4);
         end else if (sub == SUB_GAP_STATUS) begin
            step_in = shift_ff[DONE_BIT] ? (step_ff + 5'd1) : (step_ff - 5'd2);
         end else if (sensor) begin
            pump_off_in = !pump_on;
            step_in     = '0;
         end else begin
            step_in = STEPS_PER_SENSOR;
         end
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         bit_ff       <= '0;
         phase_ff     <= 1'b0;
         shift_ff     <= '0;
         raw_ff       <= '0;
         tank_val_ff  <= '0;
         tank_neg_ff  <= 1'b0;
         panel_val_ff <= '0;
         panel_neg_ff <= 1'b0;
         pump_off_ff  <= 1'b1;
      end else if (advance) begin
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         raw_ff       <= raw_in;
         tank_val_ff  <= tank_val_in;
         tank_neg_ff  <= tank_neg_in;
         panel_val_ff <= panel_val_in;
         panel_neg_ff <= panel_neg_in;
         pump_off_ff  <= pump_off_in;
      end
   end

   // line levels of this tick, readings after its update
   always_comb begin
      result.tank_clock       = 1'b1;
      result.tank_reset_line  = 1'b0;
      result.tank_data_out    = 1'b0;
      result.panel_clock      = 1'b1;
      result.panel_reset_line = 1'b0;
      result.panel_data_out   = 1'b0;
      if (active && !sensor) begin
         result.tank_clock      = clk;
         result.tank_reset_line = rst;
         result.tank_data_out   = dout;
      end else if (active) begin
         result.panel_clock      = clk;
         result.panel_reset_line = rst;
         result.panel_data_out   = dout;
      end
      result.data_drive      = drive;
      result.pump_off        = pump_off_in;
      result.tank_magnitude  = tank_val_in;
      result.tank_negative   = tank_neg_in;
      result.panel_magnitude = panel_val_in;
      result.panel_negative  = panel_neg_in;
   end

endmodule

// ===== sv/dual_thermometer_pump_controller.sv =====
// Dual three-wire thermometer master with pump control.
// Each req_ch transaction is one half-bit tick carrying the levels seen on the
// tank and panel data lines; each tick yields exactly one rsp_ch transaction
// with the clock, reset and data line levels to drive for that tick, the
// data_drive direction and the pump switch plus the latest readings.
// Tank and panel are served in turn: start conversion, optional status
// polling, then temperature and sign bytes, and the pump decision after the
// panel is read.
// The input register takes the tick at req_ch acceptance, and the sequencer
// logic loads the result register from it once the result register is free.
// Throughput is one tick per cycle while rsp_ch does not stall, set by the
// single sequencer update per cycle.
// When rsp_ch stalls the result register holds, the input register takes one
// more tick, and req_ch ready drops once both are full.
// Reset (synchronous) restarts at the tank conversion, clears readings, turns
// the pump off and loads threshold 40, tank polling on, panel polling off.
// csr_we writes register csr_index (0 threshold, 1 tank poll, 2 panel poll).
module dual_thermometer_pump_controller
   import dtpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   dtpc_req_if.sink               req_ch,
   dtpc_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff, in_valid_in;
   logic       in_tank_ff;
   logic       in_panel_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type seq_result;
   logic       out_free;
   logic       advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pump_threshold    <= THRESHOLD_RESET;
         cfg_ff.tank_poll_enable  <= TANK_POLL_RESET;
         cfg_ff.panel_poll_enable <= PANEL_POLL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PUMP_THRESHOLD:    cfg_ff.pump_threshold    <= csr_wdata[7:0];
            CSR_TANK_POLL_ENABLE:  cfg_ff.tank_poll_enable  <= csr_wdata[0];
            CSR_PANEL_POLL_ENABLE: cfg_ff.panel_poll_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_tank_ff  <= req_ch.tank_data_in;
         in_panel_ff <= req_ch.panel_data_in;
      end
   end

   dtpc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .tank_din  (in_tank_ff),
      .panel_din (in_panel_ff),
      .cfg       (cfg_ff),
      .result    (seq_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= seq_result;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.tank_clock       = out_ff.tank_clock;
   assign rsp_ch.tank_reset_line  = out_ff.tank_reset_line;
   assign rsp_ch.tank_data_out    = out_ff.tank_data_out;
   assign rsp_ch.panel_clock      = out_ff.panel_clock;
   assign rsp_ch.panel_reset_line = out_ff.panel_reset_line;
   assign rsp_ch.panel_data_out   = out_ff.panel_data_out;
   assign rsp_ch.data_drive       = out_ff.data_drive;
   assign rsp_ch.pump_off         = out_ff.pump_off;
   assign rsp_ch.tank_magnitude   = out_ff.tank_magnitude;
   assign rsp_ch.tank_negative    = out_ff.tank_negative;
   assign rsp_ch.panel_magnitude  = out_ff.panel_magnitude;
   assign rsp_ch.panel_negative   = out_ff.panel_negative;

   // only one sensor is selected at a time
   a_one_selected: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.tank_reset_line && out_ff.panel_reset_line))
      else $error("both sensors selected");

   // driving the data line needs a selected sensor
   a_drive_selected: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.data_drive) |->
         (out_ff.tank_reset_line || out_ff.panel_reset_line))
      else $error("data driven with no sensor selected");

   // a waiting tick is kept while the result register is blocked
   a_tick_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=>
         (in_valid_ff && $stable(in_tank_ff) && $stable(in_panel_ff)))
      else $error("pending tick lost");

endmodule

// ===== tb/dtpc_tb_checker.sv =====
module dtpc_tb_checker
   import dtpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   dtpc_req_if                    req_ch,
   dtpc_rsp_if                    rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // mirrored configuration and sequencer state
   cfg_type    cfg;
   logic [4:0] step;
   logic [2:0] bit_cnt;
   logic       phase;
   logic [7:0] shift;
   logic [7:0] raw_temp;
   logic [7:0] tank_mag;
   logic       tank_neg;
   logic [7:0] panel_mag;
   logic       panel_neg;
   logic       pump_off_q;

   // line levels expected for each accepted tick, oldest first
   result_type line_levels_q[$];
   int         fail_count = 0;
   int         result_index = 0;

   // one half-bit tick of the two-sensor sequencer
   function automatic result_type advance_tick(input logic tank_din, input logic panel_din);
      result_type r;
      logic [4:0] nxt;
      logic [4:0] base;
      logic [4:0] sub_raw;
      logic       sensor;
      logic       clk;
      logic       rst;
      logic       dout;
      logic       drive;
      logic       din;
      logic       neg;
      logic       poll;
      logic       pump_on;
      logic [7:0] cmd;
      logic [7:0] half;
      logic [7:0] mag;
      logic [2:0] bit_idx;
      sub_type    sub;
      nxt    = step;
      sensor = 1'b0;
      clk    = 1'b1;
      rst    = 1'b0;
      dout   = 1'b0;
      drive  = 1'b0;
      cmd    = 8'd0;
      if (step > LAST_STEP) begin
         // unused step code: one idle tick, then the tank start
         nxt     = 5'(SUB_CONVERT_CMD);
         bit_cnt = 3'd0;
         phase   = 1'b0;
      end else begin
         sensor  = (step >= STEPS_PER_SENSOR);
         base    = sensor ? STEPS_PER_SENSOR : 5'd0;
         sub_raw = step - base;
         sub     = sub_type'(sub_raw[3:0]);
         din     = sensor ? panel_din : tank_din;
         case (sub)
            SUB_GAP_CONVERT, SUB_GAP_STATUS, SUB_GAP_END: begin
               bit_cnt = 3'd0;
               phase   = 1'b0;
               if (sub == SUB_GAP_CONVERT) begin
                  poll = sensor ? cfg.panel_poll_enable : cfg.tank_poll_enable;
                  nxt  = base + (poll ? 5'(SUB_STATUS_CMD) : 5'(SUB_READ_CMD));
               end else if (sub == SUB_GAP_STATUS) begin
                  nxt = base + (shift[DONE_BIT] ? 5'(SUB_READ_CMD) : 5'(SUB_STATUS_CMD));
               end else if (sensor) begin
                  // pump decision after the panel reading
                  pump_on = !tank_neg && !panel_neg && (panel_mag > cfg.pump_threshold) &&
                            (panel_mag >= tank_mag);
                  pump_off_q = !pump_on;
                  nxt        = 5'(SUB_CONVERT_CMD);
               end else begin
                  nxt = STEPS_PER_SENSOR;
               end
            end
            default: begin
               bit_idx = bit_cnt;
               clk     = phase;
               rst     = 1'b1;
               case (sub)
                  SUB_CONVERT_CMD: cmd = CMD_CONVERT;
                  SUB_STATUS_CMD:  cmd = CMD_STATUS;
                  SUB_READ_CMD:    cmd = CMD_READ;
                  default:         cmd = 8'd0;
               endcase
               if (sub == SUB_CONVERT_CMD || sub == SUB_STATUS_CMD || sub == SUB_READ_CMD) begin
                  drive = 1'b1;
                  dout  = cmd[bit_idx];
               end else if (!clk) begin
                  // sample the active line on the clock-low tick
                  shift[bit_idx] = din;
               end
               if (clk) begin
                  if (bit_idx == 3'd7) begin
                     bit_cnt = 3'd0;
                     nxt     = step + 5'd1;
                     if (sub == SUB_TEMP_READ) begin
                        raw_temp = shift;
                     end else if (sub == SUB_SIGN_READ) begin
                        half = {1'b0, raw_temp[7:1]};
                        neg  = (shift == SIGN_NEG);
                        mag  = neg ? (NEG_BASE - half) : half;
                        if (sensor) begin
                           panel_mag = mag;
                           panel_neg = neg;
                        end else begin
                           tank_mag = mag;
                           tank_neg = neg;
                        end
                     end
                  end else begin
                     bit_cnt = bit_idx + 3'd1;
                  end
               end
               phase = ~clk;
            end
         endcase
      end
      step = nxt;

      // line levels: the idle sensor sits with clock high, reset and data low
      r.tank_clock       = 1'b1;
      r.tank_reset_line  = 1'b0;
      r.tank_data_out    = 1'b0;
      r.panel_clock      = 1'b1;
      r.panel_reset_line = 1'b0;
      r.panel_data_out   = 1'b0;
      if (!sensor) begin
         r.tank_clock      = clk;
         r.tank_reset_line = rst;
         r.tank_data_out   = dout;
      end else begin
         r.panel_clock      = clk;
         r.panel_reset_line = rst;
         r.panel_data_out   = dout;
      end
      r.data_drive      = drive;
      r.pump_off        = pump_off_q;
      r.tank_magnitude  = tank_mag;
      r.tank_negative   = tank_neg;
      r.panel_magnitude = panel_mag;
      r.panel_negative  = panel_neg;
      return r;
   endfunction

   // names of the fields that disagree
   function automatic string field_diffs(input result_type w, input result_type g);
      string s;
      s = "";
      if (w.tank_clock       !== g.tank_clock)       s = {s, " tank_clock"};
      if (w.tank_reset_line  !== g.tank_reset_line)  s = {s, " tank_reset_line"};
      if (w.tank_data_out    !== g.tank_data_out)    s = {s, " tank_data_out"};
      if (w.panel_clock      !== g.panel_clock)      s = {s, " panel_clock"};
      if (w.panel_reset_line !== g.panel_reset_line) s = {s, " panel_reset_line"};
      if (w.panel_data_out   !== g.panel_data_out)   s = {s, " panel_data_out"};
      if (w.data_drive       !== g.data_drive)       s = {s, " data_drive"};
      if (w.pump_off         !== g.pump_off)         s = {s, " pump_off"};
      if (w.tank_magnitude   !== g.tank_magnitude)   s = {s, " tank_magnitude"};
      if (w.tank_negative    !== g.tank_negative)    s = {s, " tank_negative"};
      if (w.panel_magnitude  !== g.panel_magnitude)  s = {s, " panel_magnitude"};
      if (w.panel_negative   !== g.panel_negative)   s = {s, " panel_negative"};
      return s;
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin
      result_type got;
      result_type want;
      string      diff;
      if (reset) begin
         cfg        = '{THRESHOLD_RESET, TANK_POLL_RESET, PANEL_POLL_RESET};
         step       = 5'(SUB_CONVERT_CMD);
         bit_cnt    = 3'd0;
         phase      = 1'b0;
         shift      = 8'd0;
         raw_temp   = 8'd0;
         tank_mag   = 8'd0;
         tank_neg   = 1'b0;
         panel_mag  = 8'd0;
         panel_neg  = 1'b0;
         pump_off_q = 1'b1;
         line_levels_q.delete();
      end else begin
         // predict on every accepted tick transaction
         if (req_ch.valid && req_ch.ready)
            line_levels_q.push_back(advance_tick(req_ch.tank_data_in, req_ch.panel_data_in));

         // compare every accepted result transaction with the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.tank_clock, rsp_ch.tank_reset_line, rsp_ch.tank_data_out,
                   rsp_ch.panel_clock, rsp_ch.panel_reset_line, rsp_ch.panel_data_out,
                   rsp_ch.data_drive, rsp_ch.pump_off, rsp_ch.tank_magnitude,
                   rsp_ch.tank_negative, rsp_ch.panel_magnitude, rsp_ch.panel_negative};
            if (line_levels_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result %0d: unexpected transaction, got %h", result_index, got);
            end else begin
               want = line_levels_q.pop_front();
               diff = field_diffs(want, got);
               if (diff != "") begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result %0d: mismatch in%s, expected %p, got %p",
                              result_index, diff, want, got);
               end
            end
            result_index++;
         end

         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_PUMP_THRESHOLD:    cfg.pump_threshold    = csr_wdata;
               CSR_TANK_POLL_ENABLE:  cfg.tank_poll_enable  = csr_wdata[0];
               CSR_PANEL_POLL_ENABLE: cfg.panel_poll_enable = csr_wdata[0];
               default: ;
            endcase
         end
      end
      mismatches  <= fail_count;
      outstanding <= line_levels_q.size();
   end

endmodule

// ===== tb/tb_dual_thermometer_pump_controller.sv =====
module tb_dual_thermometer_pump_controller;
   timeunit 1ns;
   timeprecision 1ps;
   import dtpc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 64;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatches;
   int                     outstanding;

   dtpc_req_if req_ch ();
   dtpc_rsp_if rsp_ch ();

   // pacing controls
   int          send_idle_pct = 11;
   int          recv_idle_pct = 61;
   int          hold_reqs = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int unsigned cycles = 0;

   // data line levels come in runs so sign bytes of all ones or all zeros are common
   logic tank_lvl = 1'b0;
   logic panel_lvl = 1'b0;
   int   tank_run = 0;
   int   panel_run = 0;

   dual_thermometer_pump_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dtpc_tb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen <= hold_reqs;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result receiver
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset)
            rsp_ch.ready <= 1'b0;
         else
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // one tick transaction, with a random gap ahead of it
   task automatic send_tick(input logic tank_din, input logic panel_din);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.tank_data_in  <= tank_din;
      req_ch.panel_data_in <= panel_din;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic next_level(inout logic level, inout int run_left);
      if (run_left == 0) begin
         level    = 1'($urandom_range(0, 1));
         run_left = ($urandom_range(0, 1) != 0) ? $urandom_range(16, 40) : $urandom_range(1, 3);
      end
      run_left--;
   endtask

   // register writes on an idle block, poll bits carry random upper bits
   task automatic load_settings(input logic [7:0] threshold, input logic tank_poll,
                                input logic panel_poll, input bit touch_spare);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PUMP_THRESHOLD;
      csr_wdata <= threshold;
      @(posedge clock);
      csr_index <= CSR_TANK_POLL_ENABLE;
      csr_wdata <= {7'($urandom_range(0, 127)), tank_poll};
      @(posedge clock);
      csr_index <= CSR_PANEL_POLL_ENABLE;
      csr_wdata <= {7'($urandom_range(0, 127)), panel_poll};
      @(posedge clock);
      if (touch_spare) begin
         csr_index <= CSR_SPARE_INDEX;
         csr_wdata <= 8'($urandom_range(0, 255));
         @(posedge clock);
      end
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // random ticks with an optional hold-off and sender pause
   task automatic send_random(input int count, input int hold_at, input int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_reqs <= hold_reqs + 1;
         if (i == pause_at) wait_drained();
         next_level(tank_lvl, tank_run);
         next_level(panel_lvl, panel_run);
         send_tick(tank_lvl, panel_lvl);
      end
   endtask

   // stimulus and verdict
   initial begin
      int k;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= CSR_PUMP_THRESHOLD;
      csr_wdata            <= 8'd0;
      req_ch.valid         <= 1'b0;
      req_ch.tank_data_in  <= 1'b0;
      req_ch.panel_data_in <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: every level combination on both lines
      for (int i = 0; i < 24; i++) begin
         k = i / 6;
         send_tick(k == 1 || k == 2, k == 1 || k == 3);
      end
      send_random(200, -1, -1);

      // zero threshold, panel polling only
      load_settings(8'd0, 1'b0, 1'b1, 1'b0);
      send_random(200, 80, -1);

      // top threshold, both polled, sender idles more than receiver
      load_settings(8'd128, 1'b1, 1'b1, 1'b0);
      send_idle_pct = 61;
      recv_idle_pct <= 11;
      send_random(200, -1, 100);

      // threshold above the reading range, no polling, spare index poked
      load_settings(8'd200, 1'b0, 1'b0, 1'b1);
      send_random(250, 60, -1);

      // random settings, no idling
      load_settings(8'($urandom_range(0, 128)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      send_random(250, -1, 120);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
